@@ sv/tdbl_pkg.sv @@
// Shared constants, codes and types for the 2D bilinear table lookup unit.
// Used by every module of the block; depends on nothing.
package tdbl_pkg;

    // Grid geometry
    localparam int MAX_CELLS  = 63;
    localparam int GRID_SIDE  = MAX_CELLS + 1;
    localparam int IDX_W      = $clog2(GRID_SIDE);
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NBANKS     = 4;

    // Field widths
    localparam int VAL_W      = 32;
    localparam int POS_W      = 32;
    localparam int SCALE_W    = 31;
    localparam int CELLS_W    = 6;
    localparam int MODE_W     = 2;
    localparam int FRAC_W     = 16;
    localparam int WFRAC_W    = FRAC_W + 1;
    localparam int WEIGHT_W   = 2 * FRAC_W + 1;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream payload layout
    localparam int IN_FIELDS_W   = 2 * POS_W + 2 * IDX_W + VAL_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = VAL_W;

    localparam logic [WFRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

    // Lookup modes
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd2;

    // Item kinds
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_X_CELLS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CELLS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_OUTPUT = 3'd7;

    // Per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } pipe_en_t;

    // Grid write request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] data;
    } mem_wr_t;

    // Registered read data of the four banks, indexed {row parity, col parity}
    typedef logic [NBANKS-1:0][VAL_W-1:0] bank_data_t;

endpackage

@@ sv/table_2d_bilinear_lookup_unit.sv @@
// 2D table lookup, Q16.16: one transaction per cycle while s_tready is high.
// Seven register stages: offset, scale multiply, floor/clamp, banked grid read, weighted
// products, pair sums, final sum and output; the four-bank grid gives one cell a cycle,
// unless the pipeline stalls. Reset: config returns to mode 1, unit scales, 63 cells;
// the grid is then swept to zero with s_tready low, config writes still taken.
module table_2d_bilinear_lookup_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // x_pos[31:0], y_pos[63:32], row_index[69:64], col_index[75:70],
    // entry_value[107:76], zero fill[111:108]
    input  logic [tdbl_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_value[31:0]
    output logic [tdbl_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [tdbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdbl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int X_LSB   = 0;
    localparam int Y_LSB   = X_LSB + tdbl_pkg::POS_W;
    localparam int ROW_LSB = Y_LSB + tdbl_pkg::POS_W;
    localparam int COL_LSB = ROW_LSB + tdbl_pkg::IDX_W;
    localparam int VAL_LSB = COL_LSB + tdbl_pkg::IDX_W;

    logic [tdbl_pkg::MODE_W-1:0]   mode_reg;
    logic [tdbl_pkg::POS_W-1:0]    x_origin_reg;
    logic [tdbl_pkg::POS_W-1:0]    y_origin_reg;
    logic [tdbl_pkg::SCALE_W-1:0]  x_scale_reg;
    logic [tdbl_pkg::SCALE_W-1:0]  y_scale_reg;
    logic [tdbl_pkg::CELLS_W-1:0]  x_cells_reg;
    logic [tdbl_pkg::CELLS_W-1:0]  y_cells_reg;
    logic [tdbl_pkg::VAL_W-1:0]    fixed_output_reg;

    logic [7:1]                    valid_reg;
    logic [7:1]                    ready;
    tdbl_pkg::pipe_en_t            en;
    tdbl_pkg::mem_wr_t             wr1_reg;
    tdbl_pkg::mem_wr_t             wr2_reg;
    tdbl_pkg::mem_wr_t             wr3_reg;
    tdbl_pkg::mem_wr_t             wr_req;
    tdbl_pkg::mem_wr_t             wr_in;
    tdbl_pkg::bank_data_t          rd_data;
    logic                          clearing;
    logic                          near;
    logic [tdbl_pkg::IDX_W-1:0]    x_idx;
    logic [tdbl_pkg::IDX_W-1:0]    y_idx;
    logic [tdbl_pkg::WFRAC_W-1:0]  x_frac;
    logic [tdbl_pkg::WFRAC_W-1:0]  y_frac;
    logic [tdbl_pkg::VAL_W-1:0]    result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= tdbl_pkg::MODE_BLEND;
            x_origin_reg     <= '0;
            y_origin_reg     <= '0;
            x_scale_reg      <= tdbl_pkg::SCALE_W'(32'h0001_0000);
            y_scale_reg      <= tdbl_pkg::SCALE_W'(32'h0001_0000);
            x_cells_reg      <= tdbl_pkg::CELLS_W'(tdbl_pkg::MAX_CELLS);
            y_cells_reg      <= tdbl_pkg::CELLS_W'(tdbl_pkg::MAX_CELLS);
            fixed_output_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tdbl_pkg::REG_MODE:         mode_reg <= cfg_data[tdbl_pkg::MODE_W-1:0];
                tdbl_pkg::REG_X_ORIGIN:     x_origin_reg <= cfg_data[tdbl_pkg::POS_W-1:0];
                tdbl_pkg::REG_Y_ORIGIN:     y_origin_reg <= cfg_data[tdbl_pkg::POS_W-1:0];
                tdbl_pkg::REG_X_SCALE:      x_scale_reg <= cfg_data[tdbl_pkg::SCALE_W-1:0];
                tdbl_pkg::REG_Y_SCALE:      y_scale_reg <= cfg_data[tdbl_pkg::SCALE_W-1:0];
                tdbl_pkg::REG_X_CELLS:      x_cells_reg <= cfg_data[tdbl_pkg::CELLS_W-1:0];
                tdbl_pkg::REG_Y_CELLS:      y_cells_reg <= cfg_data[tdbl_pkg::CELLS_W-1:0];
                tdbl_pkg::REG_FIXED_OUTPUT: fixed_output_reg <= cfg_data[tdbl_pkg::VAL_W-1:0];
                default:                    ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on this cycle
    always_comb
    begin
        ready[7] = !valid_reg[7] || m_tready;
        for (int k = 6; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign en.s1 = ready[1];
    assign en.s2 = ready[2];
    assign en.s3 = ready[3];
    assign en.s4 = ready[4];
    assign en.s5 = ready[5];
    assign en.s6 = ready[6];
    assign en.s7 = ready[7];

    assign s_tready = ready[1] && !clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[1]) valid_reg[1] <= s_tvalid && !clearing;
            if (ready[2]) valid_reg[2] <= valid_reg[1];
            if (ready[3]) valid_reg[3] <= valid_reg[2];
            // Write transactions retire at the grid stage
            if (ready[4]) valid_reg[4] <= valid_reg[3] && !wr3_reg.we;
            if (ready[5]) valid_reg[5] <= valid_reg[4];
            if (ready[6]) valid_reg[6] <= valid_reg[5];
            if (ready[7]) valid_reg[7] <= valid_reg[6];
        end
    end

    // Carry the write payload alongside the coordinate stages
    assign wr_in.we   = (s_tuser == tdbl_pkg::FUNC_WRITE);
    assign wr_in.row  = s_tdata[ROW_LSB +: tdbl_pkg::IDX_W];
    assign wr_in.col  = s_tdata[COL_LSB +: tdbl_pkg::IDX_W];
    assign wr_in.data = s_tdata[VAL_LSB +: tdbl_pkg::VAL_W];

    always_ff @(posedge clk)
    begin
        if (ready[1]) wr1_reg <= wr_in;
        if (ready[2]) wr2_reg <= wr1_reg;
        if (ready[3]) wr3_reg <= wr2_reg;
    end

    always_comb
    begin
        wr_req    = wr3_reg;
        wr_req.we = wr3_reg.we && valid_reg[3] && ready[4];
    end

    assign near = (mode_reg == tdbl_pkg::MODE_NEAREST);

    tdbl_axis u_axis_x
    (
        .clk    (clk),
        .en     (en),
        .near   (near),
        .pos    (s_tdata[X_LSB +: tdbl_pkg::POS_W]),
        .origin (x_origin_reg),
        .scale  (x_scale_reg),
        .cells  (x_cells_reg),
        .idx    (x_idx),
        .frac   (x_frac)
    );

    tdbl_axis u_axis_y
    (
        .clk    (clk),
        .en     (en),
        .near   (near),
        .pos    (s_tdata[Y_LSB +: tdbl_pkg::POS_W]),
        .origin (y_origin_reg),
        .scale  (y_scale_reg),
        .cells  (y_cells_reg),
        .idx    (y_idx),
        .frac   (y_frac)
    );

    tdbl_grid_mem u_grid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (ready[4]),
        .rd_row   (x_idx),
        .rd_col   (y_idx),
        .wr       (wr_req),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    tdbl_blend u_blend
    (
        .clk         (clk),
        .en          (en),
        .mode        (mode_reg),
        .fixed_value (fixed_output_reg),
        .t           (x_frac),
        .u           (y_frac),
        .par         ({x_idx[0], y_idx[0]}),
        .rd_data     (rd_data),
        .result      (result)
    );

    assign m_tvalid = valid_reg[7];
    assign m_tdata  = result;

    a_empty_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> (valid_reg == '0)
    ) else $error("transaction in flight during grid clear");

    a_row_in_cell_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !wr3_reg.we && mode_reg == tdbl_pkg::MODE_BLEND)
        |-> (x_idx < x_cells_reg) || (x_idx == '0)
    ) else $error("blend row index beyond last cell");

    a_col_in_cell_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !wr3_reg.we && mode_reg == tdbl_pkg::MODE_BLEND)
        |-> (y_idx < y_cells_reg) || (y_idx == '0)
    ) else $error("blend column index beyond last cell");

    a_frac_one_exact: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !wr3_reg.we)
        |-> (!x_frac[tdbl_pkg::FRAC_W] || x_frac[tdbl_pkg::FRAC_W-1:0] == '0)
         && (!y_frac[tdbl_pkg::FRAC_W] || y_frac[tdbl_pkg::FRAC_W-1:0] == '0)
    ) else $error("fraction above one");

endmodule

@@ sv/tdbl_axis.sv @@
// One coordinate axis: offset, scale to a Q32.32 grid coordinate, floor and clamp.
// Three pipeline stages; depends on tdbl_pkg.
module tdbl_axis
(
    input  logic                            clk,
    input  tdbl_pkg::pipe_en_t              en,
    input  logic                            near,
    input  logic [tdbl_pkg::POS_W-1:0]      pos,
    input  logic [tdbl_pkg::POS_W-1:0]      origin,
    input  logic [tdbl_pkg::SCALE_W-1:0]    scale,
    input  logic [tdbl_pkg::CELLS_W-1:0]    cells,
    output logic [tdbl_pkg::IDX_W-1:0]      idx,
    output logic [tdbl_pkg::WFRAC_W-1:0]    frac
);

    function automatic logic [tdbl_pkg::IDX_W-1:0] used_cells
    (
        input logic [tdbl_pkg::CELLS_W-1:0] c
    );
        if (c == '0)
        begin
            return tdbl_pkg::IDX_W'(1);
        end
        if (int'(c) > tdbl_pkg::MAX_CELLS)
        begin
            return tdbl_pkg::IDX_W'(tdbl_pkg::MAX_CELLS);
        end
        return tdbl_pkg::IDX_W'(c);
    endfunction

    logic signed [tdbl_pkg::POS_W:0]                     diff_reg;
    logic signed [tdbl_pkg::POS_W:0]                     diff_next;
    logic signed [tdbl_pkg::POS_W+tdbl_pkg::SCALE_W+1:0] prod_full;
    logic [tdbl_pkg::ACC_W-1:0]                          coord_reg;
    logic [tdbl_pkg::POS_W-1:0]                          coord_int;
    logic                                                coord_neg;
    logic [tdbl_pkg::IDX_W-1:0]                          used;
    logic [tdbl_pkg::IDX_W-1:0]                          idx_reg;
    logic [tdbl_pkg::IDX_W-1:0]                          idx_next;
    logic [tdbl_pkg::WFRAC_W-1:0]                        frac_reg;
    logic [tdbl_pkg::WFRAC_W-1:0]                        frac_next;

    assign diff_next = $signed({pos[tdbl_pkg::POS_W-1], pos})
                     - $signed({origin[tdbl_pkg::POS_W-1], origin});
    assign prod_full = diff_reg * $signed({1'b0, scale});

    // Integer part of the Q32.32 coordinate is its upper word: floor by construction
    assign coord_int = coord_reg[tdbl_pkg::ACC_W-1 -: tdbl_pkg::POS_W];
    assign coord_neg = coord_reg[tdbl_pkg::ACC_W-1];
    assign used      = used_cells(cells);

    always_comb
    begin
        idx_next  = coord_int[tdbl_pkg::IDX_W-1:0];
        frac_next = {1'b0, coord_reg[tdbl_pkg::POS_W-1 -: tdbl_pkg::FRAC_W]};
        if (near)
        begin
            frac_next = '0;
            if (coord_neg)
            begin
                idx_next = '0;
            end
            else if (coord_int > tdbl_pkg::POS_W'(used))
            begin
                idx_next = used;
            end
        end
        else
        begin
            // Pin to the first or last cell with the fraction at 0 or 1
            if (coord_neg)
            begin
                idx_next  = '0;
                frac_next = '0;
            end
            else if (coord_int >= tdbl_pkg::POS_W'(used))
            begin
                idx_next  = used - tdbl_pkg::IDX_W'(1);
                frac_next = tdbl_pkg::FRAC_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            diff_reg <= diff_next;
        end
        if (en.s2)
        begin
            coord_reg <= prod_full[tdbl_pkg::ACC_W-1:0];
        end
        if (en.s3)
        begin
            idx_reg  <= idx_next;
            frac_reg <= frac_next;
        end
    end

    assign idx  = idx_reg;
    assign frac = frac_reg;

endmodule

@@ sv/tdbl_grid_mem.sv @@
// Sample grid split into four banks by row and column parity, so the four
// corners of a cell are read in the same cycle. Clears itself after reset; uses tdbl_pkg.
module tdbl_grid_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [tdbl_pkg::IDX_W-1:0]    rd_row,
    input  logic [tdbl_pkg::IDX_W-1:0]    rd_col,
    input  tdbl_pkg::mem_wr_t             wr,
    output tdbl_pkg::bank_data_t          rd_data,
    output logic                          clearing
);

    localparam logic CLR_DONE  = 1'b0;
    localparam logic CLR_SWEEP = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [tdbl_pkg::BANK_AW-1:0]  clr_addr_reg;
    logic [tdbl_pkg::BANK_AW-1:0]  clr_addr_next;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            CLR_SWEEP:
            begin
                clr_addr_next = clr_addr_reg + tdbl_pkg::BANK_AW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = CLR_DONE;
                end
            end
            CLR_DONE:
            begin
                state_next = CLR_DONE;
            end
            default:
            begin
                state_next = CLR_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CLR_SWEEP;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clearing = (state_reg == CLR_SWEEP);

    genvar b;
    generate
        for (b = 0; b < tdbl_pkg::NBANKS; b++)
        begin : g_bank
            localparam logic [1:0] BSEL = 2'(b);

            logic [tdbl_pkg::VAL_W-1:0]   mem [tdbl_pkg::BANK_DEPTH];
            logic [tdbl_pkg::VAL_W-1:0]   q_reg;
            logic [tdbl_pkg::IDX_W-1:0]   row_sel;
            logic [tdbl_pkg::IDX_W-1:0]   col_sel;
            logic [tdbl_pkg::BANK_AW-1:0] rd_addr;
            logic [tdbl_pkg::BANK_AW-1:0] wr_addr;
            logic                         wr_en;
            logic [tdbl_pkg::VAL_W-1:0]   wr_val;

            // This bank holds either the cell's base row/column or the next one
            assign row_sel = (rd_row[0] == BSEL[1]) ? rd_row : rd_row + tdbl_pkg::IDX_W'(1);
            assign col_sel = (rd_col[0] == BSEL[0]) ? rd_col : rd_col + tdbl_pkg::IDX_W'(1);
            assign rd_addr = {row_sel[tdbl_pkg::IDX_W-1:1], col_sel[tdbl_pkg::IDX_W-1:1]};

            assign wr_en   = clearing || (wr.we && ({wr.row[0], wr.col[0]} == BSEL));
            assign wr_addr = clearing ? clr_addr_reg
                                      : {wr.row[tdbl_pkg::IDX_W-1:1], wr.col[tdbl_pkg::IDX_W-1:1]};
            assign wr_val  = clearing ? '0 : wr.data;

            always_ff @(posedge clk)
            begin
                if (wr_en)
                begin
                    mem[wr_addr] <= wr_val;
                end
                if (rd_en)
                begin
                    q_reg <= mem[rd_addr];
                end
            end

            assign rd_data[b] = q_reg;
        end
    endgenerate

    a_no_write_during_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !wr.we
    ) else $error("grid write requested during clear sweep");

endmodule

@@ sv/tdbl_blend.sv @@
// Bilinear weights, weighted corner products, sum and rounding, plus the
// nearest and fixed-value paths; stages four to seven. Uses tdbl_pkg.
module tdbl_blend
(
    input  logic                           clk,
    input  tdbl_pkg::pipe_en_t             en,
    input  logic [tdbl_pkg::MODE_W-1:0]    mode,
    input  logic [tdbl_pkg::VAL_W-1:0]     fixed_value,
    input  logic [tdbl_pkg::WFRAC_W-1:0]   t,
    input  logic [tdbl_pkg::WFRAC_W-1:0]   u,
    input  logic [1:0]                     par,
    input  tdbl_pkg::bank_data_t           rd_data,
    output logic [tdbl_pkg::VAL_W-1:0]     result
);

    localparam int WPROD_W = 2 * tdbl_pkg::WFRAC_W;
    localparam int SPROD_W = tdbl_pkg::WEIGHT_W + tdbl_pkg::VAL_W + 1;
    localparam logic [tdbl_pkg::ACC_W-1:0] ROUND_HALF =
        tdbl_pkg::ACC_W'(1) << (2 * tdbl_pkg::FRAC_W - 1);

    logic [tdbl_pkg::WFRAC_W-1:0]  t_c;
    logic [tdbl_pkg::WFRAC_W-1:0]  u_c;
    logic [WPROD_W-1:0]            w00_full;
    logic [WPROD_W-1:0]            w10_full;
    logic [WPROD_W-1:0]            w11_full;
    logic [WPROD_W-1:0]            w01_full;
    logic [tdbl_pkg::WEIGHT_W-1:0] w00_reg;
    logic [tdbl_pkg::WEIGHT_W-1:0] w10_reg;
    logic [tdbl_pkg::WEIGHT_W-1:0] w11_reg;
    logic [tdbl_pkg::WEIGHT_W-1:0] w01_reg;
    logic [1:0]                    par_reg;

    logic signed [tdbl_pkg::VAL_W-1:0] s00;
    logic signed [tdbl_pkg::VAL_W-1:0] s10;
    logic signed [tdbl_pkg::VAL_W-1:0] s11;
    logic signed [tdbl_pkg::VAL_W-1:0] s01;
    logic signed [SPROD_W-1:0]         p00_full;
    logic signed [SPROD_W-1:0]         p10_full;
    logic signed [SPROD_W-1:0]         p11_full;
    logic signed [SPROD_W-1:0]         p01_full;
    logic [tdbl_pkg::ACC_W-1:0]        p00_reg;
    logic [tdbl_pkg::ACC_W-1:0]        p10_reg;
    logic [tdbl_pkg::ACC_W-1:0]        p11_reg;
    logic [tdbl_pkg::ACC_W-1:0]        p01_reg;
    logic [tdbl_pkg::VAL_W-1:0]        direct_next;
    logic [tdbl_pkg::VAL_W-1:0]        direct5_reg;
    logic [tdbl_pkg::VAL_W-1:0]        direct6_reg;
    logic                              blend5_reg;
    logic                              blend6_reg;

    logic [tdbl_pkg::ACC_W-1:0]        pair_a_reg;
    logic [tdbl_pkg::ACC_W-1:0]        pair_b_reg;
    logic [tdbl_pkg::ACC_W-1:0]        sum_total;
    logic [tdbl_pkg::VAL_W-1:0]        result_reg;
    logic [tdbl_pkg::VAL_W-1:0]        result_next;

    // Stage 4: weights in parallel with the bank reads
    assign t_c      = tdbl_pkg::FRAC_ONE - t;
    assign u_c      = tdbl_pkg::FRAC_ONE - u;
    assign w00_full = t_c * u_c;
    assign w10_full = t * u_c;
    assign w11_full = t * u;
    assign w01_full = t_c * u;

    // Stage 5: map banks back to cell corners, then weight them
    assign s00 = $signed(rd_data[par_reg]);
    assign s10 = $signed(rd_data[{~par_reg[1], par_reg[0]}]);
    assign s11 = $signed(rd_data[~par_reg]);
    assign s01 = $signed(rd_data[{par_reg[1], ~par_reg[0]}]);

    assign p00_full = $signed({1'b0, w00_reg}) * s00;
    assign p10_full = $signed({1'b0, w10_reg}) * s10;
    assign p11_full = $signed({1'b0, w11_reg}) * s11;
    assign p01_full = $signed({1'b0, w01_reg}) * s01;

    always_comb
    begin
        case (mode)
            tdbl_pkg::MODE_NEAREST: direct_next = s00;
            tdbl_pkg::MODE_FIXED:   direct_next = fixed_value;
            default:                direct_next = '0;
        endcase
    end

    // Stage 7: the blend is a convex sum, so the low 64 bits are exact
    assign sum_total   = pair_a_reg + pair_b_reg + ROUND_HALF;
    assign result_next = blend6_reg ? sum_total[tdbl_pkg::ACC_W-1 -: tdbl_pkg::VAL_W]
                                    : direct6_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            w00_reg <= w00_full[tdbl_pkg::WEIGHT_W-1:0];
            w10_reg <= w10_full[tdbl_pkg::WEIGHT_W-1:0];
            w11_reg <= w11_full[tdbl_pkg::WEIGHT_W-1:0];
            w01_reg <= w01_full[tdbl_pkg::WEIGHT_W-1:0];
            par_reg <= par;
        end
        if (en.s5)
        begin
            p00_reg     <= p00_full[tdbl_pkg::ACC_W-1:0];
            p10_reg     <= p10_full[tdbl_pkg::ACC_W-1:0];
            p11_reg     <= p11_full[tdbl_pkg::ACC_W-1:0];
            p01_reg     <= p01_full[tdbl_pkg::ACC_W-1:0];
            direct5_reg <= direct_next;
            blend5_reg  <= (mode == tdbl_pkg::MODE_BLEND);
        end
        if (en.s6)
        begin
            pair_a_reg  <= p00_reg + p10_reg;
            pair_b_reg  <= p11_reg + p01_reg;
            direct6_reg <= direct5_reg;
            blend6_reg  <= blend5_reg;
        end
        if (en.s7)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
